>>> hdl/vfcm_pkg.sv
// ----------------------------------------------------------------------------
// vfcm_pkg
// shared types, tables and helpers for the voxel face cull mesher
// ----------------------------------------------------------------------------
package vfcm_pkg;

  localparam int NUM_FACES   = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [7:0] AIR_ID        = 8'd0;
  localparam logic [7:0] CLEAR_WATER_A = 8'd8;
  localparam logic [7:0] CLEAR_WATER_B = 8'd9;
  localparam logic [7:0] CLEAR_LEAVES  = 8'd18;
  localparam logic [7:0] CLEAR_GLASS   = 8'd20;
  localparam logic [7:0] TILE_ID_MUL   = 8'd17;
  localparam logic [7:0] TILE_DATA_MUL = 8'd5;

  localparam logic REG_CHUNK_X = 1'b0;
  localparam logic REG_CHUNK_Z = 1'b1;

  localparam logic [2:0] LAST_TRI_VERT = 3'd5;

  // corner offsets as {x, y, z}
  localparam logic [2:0] FACE_CORNER [0:5][0:3] = '{
    '{3'b100, 3'b110, 3'b111, 3'b101},
    '{3'b001, 3'b011, 3'b010, 3'b000},
    '{3'b010, 3'b011, 3'b111, 3'b110},
    '{3'b001, 3'b000, 3'b100, 3'b101},
    '{3'b101, 3'b111, 3'b011, 3'b001},
    '{3'b000, 3'b010, 3'b110, 3'b100}
  };

  // {u, v}
  localparam logic [1:0] CORNER_UV [0:3] = '{2'b01, 2'b00, 2'b10, 2'b11};
  localparam logic [1:0] TRI_ORDER [0:5] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3};

  typedef struct packed {
    logic [16:0] base_x;
    logic [7:0]  base_y;
    logic [16:0] base_z;
    logic [7:0]  tile_base;
    logic [3:0]  light;
    logic        clear;
    logic [5:0]  face_mask;
  } entry_t;

  function automatic logic is_clear(input logic [7:0] id);
    return (id == CLEAR_WATER_A) || (id == CLEAR_WATER_B) ||
           (id == CLEAR_LEAVES) || (id == CLEAR_GLASS);
  endfunction

  function automatic logic face_shows(input logic [7:0] cur, input logic [7:0] nb);
    logic ct;
    logic nt;
    ct = is_clear(cur);
    nt = is_clear(nb);
    if (nb == AIR_ID) return 1'b1;
    if (!ct) return nt;
    return !nt || (nb != cur);
  endfunction

  function automatic logic [2:0] lowest_face(input logic [5:0] mask);
    logic [2:0] f;
    f = 3'd0;
    priority if (mask[0]) f = 3'd0;
    else if (mask[1]) f = 3'd1;
    else if (mask[2]) f = 3'd2;
    else if (mask[3]) f = 3'd3;
    else if (mask[4]) f = 3'd4;
    else f = 3'd5;
    return f;
  endfunction

endpackage

>>> hdl/vfcm_front.sv
// ----------------------------------------------------------------------------
// vfcm_front
// scan position, origin registers and face classification of each voxel
// ----------------------------------------------------------------------------
module vfcm_front #(
  parameter int CHUNK_WIDTH  = 16,
  parameter int CHUNK_DEPTH  = 16,
  parameter int CHUNK_HEIGHT = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             q_full,
  input  logic [7:0]       block_kind,
  input  logic [3:0]       block_variant,
  input  logic [3:0]       sky_level,
  input  logic [3:0]       emitted_level,
  input  logic [7:0]       nbr_pos_x,
  input  logic [7:0]       nbr_neg_x,
  input  logic [7:0]       nbr_pos_y,
  input  logic [7:0]       nbr_neg_y,
  input  logic [7:0]       nbr_pos_z,
  input  logic [7:0]       nbr_neg_z,
  input  logic             cfg_wr,
  input  logic             cfg_index,
  input  logic [11:0]      cfg_data,
  output logic             push,
  output vfcm_pkg::entry_t push_entry
);
  import vfcm_pkg::*;

  localparam int XW = (CHUNK_WIDTH > 1) ? $clog2(CHUNK_WIDTH) : 1;
  localparam int ZW = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1;
  localparam int YW = (CHUNK_HEIGHT > 1) ? $clog2(CHUNK_HEIGHT) : 1;
  localparam logic [XW-1:0] X_LAST = XW'(CHUNK_WIDTH - 1);
  localparam logic [ZW-1:0] Z_LAST = ZW'(CHUNK_DEPTH - 1);
  localparam logic [YW-1:0] Y_LAST = YW'(CHUNK_HEIGHT - 1);
  localparam logic [16:0] CW17 = 17'(CHUNK_WIDTH);
  localparam logic [16:0] CD17 = 17'(CHUNK_DEPTH);

  logic [11:0]   cx_r;
  logic [11:0]   cz_r;
  logic [XW-1:0] scan_x_r, scan_x_nxt;
  logic [ZW-1:0] scan_z_r, scan_z_nxt;
  logic [YW-1:0] scan_y_r, scan_y_nxt;
  logic          accept;
  logic [5:0]    mask;
  logic [16:0]   cx_ext;
  logic [16:0]   cz_ext;

  assign accept = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cz_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_CHUNK_X: cx_r <= cfg_data;
        REG_CHUNK_Z: cz_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    scan_x_nxt = scan_x_r;
    scan_z_nxt = scan_z_r;
    scan_y_nxt = scan_y_r + YW'(1);
    if (scan_y_r == Y_LAST) begin
      scan_y_nxt = '0;
      scan_z_nxt = scan_z_r + ZW'(1);
      if (scan_z_r == Z_LAST) begin
        scan_z_nxt = '0;
        scan_x_nxt = (scan_x_r == X_LAST) ? '0 : scan_x_r + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_x_r <= '0;
      scan_z_r <= '0;
      scan_y_r <= '0;
    end else if (accept) begin
      scan_x_r <= scan_x_nxt;
      scan_z_r <= scan_z_nxt;
      scan_y_r <= scan_y_nxt;
    end
  end

  assign mask = {face_shows(block_kind, nbr_neg_z), face_shows(block_kind, nbr_pos_z),
                 face_shows(block_kind, nbr_neg_y), face_shows(block_kind, nbr_pos_y),
                 face_shows(block_kind, nbr_neg_x), face_shows(block_kind, nbr_pos_x)};

  assign cx_ext = {{5{cx_r[11]}}, cx_r};
  assign cz_ext = {{5{cz_r[11]}}, cz_r};

  assign push = accept && (block_kind != AIR_ID) && (mask != '0);

  always_comb begin
    push_entry.base_x    = cx_ext * CW17 + 17'(scan_x_r);
    push_entry.base_z    = cz_ext * CD17 + 17'(scan_z_r);
    push_entry.base_y    = 8'(scan_y_r);
    push_entry.tile_base = block_kind * TILE_ID_MUL + {4'd0, block_variant} * TILE_DATA_MUL;
    push_entry.light     = (sky_level > emitted_level) ? sky_level : emitted_level;
    push_entry.clear     = is_clear(block_kind);
    push_entry.face_mask = mask;
  end

endmodule

>>> hdl/vfcm_queue.sv
// ----------------------------------------------------------------------------
// vfcm_queue
// short queue of classified voxels between front and back
// ----------------------------------------------------------------------------
module vfcm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  vfcm_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             q_valid,
  output vfcm_pkg::entry_t head
);
  import vfcm_pkg::*;

  entry_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign head    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      unique case ({push, pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> hdl/vfcm_back.sv
// ----------------------------------------------------------------------------
// vfcm_back
// walks visible faces of one voxel and emits six vertices per face
// ----------------------------------------------------------------------------
module vfcm_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  vfcm_pkg::entry_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [16:0]      vertex_x,
  output logic [7:0]       vertex_y,
  output logic [16:0]      vertex_z,
  output logic [4:0]       tex_u,
  output logic [4:0]       tex_v,
  output logic [3:0]       light_level,
  output logic             to_translucent,
  output logic             last_vertex
);
  import vfcm_pkg::*;

  entry_t      cur_r;
  logic        busy_r;
  logic [5:0]  rem_r;
  logic [2:0]  k_r;
  logic        out_valid_r;
  logic [16:0] vx_r;
  logic [7:0]  vy_r;
  logic [16:0] vz_r;
  logic [4:0]  u_r;
  logic [4:0]  v_r;
  logic [3:0]  light_r;
  logic        clear_r;
  logic        last_r;

  logic        adv;
  logic        emit;
  logic [2:0]  face;
  logic [1:0]  corner;
  logic [2:0]  offs;
  logic [1:0]  uv;
  logic [7:0]  tile;
  logic [5:0]  rem_clr;
  logic        face_done;
  logic        fin;

  assign adv       = !out_valid_r || !out_stall;
  assign emit      = busy_r && adv;
  assign face      = lowest_face(rem_r);
  assign corner    = TRI_ORDER[k_r];
  assign offs      = FACE_CORNER[face][corner];
  assign uv        = CORNER_UV[corner];
  assign tile      = cur_r.tile_base + {5'd0, face};
  assign rem_clr   = rem_r & ~(6'd1 << face);
  assign face_done = (k_r == LAST_TRI_VERT);
  assign fin       = emit && face_done && (rem_clr == '0);
  assign pop       = q_valid && (!busy_r || fin);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rem_r  <= '0;
      k_r    <= '0;
    end else if (pop) begin
      busy_r <= 1'b1;
      rem_r  <= head.face_mask;
      k_r    <= '0;
    end else if (emit) begin
      if (face_done) begin
        rem_r  <= rem_clr;
        k_r    <= '0;
        busy_r <= (rem_clr != '0);
      end else begin
        k_r <= k_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur_r <= head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      vx_r    <= cur_r.base_x + {16'd0, offs[2]};
      vy_r    <= cur_r.base_y + {7'd0, offs[1]};
      vz_r    <= cur_r.base_z + {16'd0, offs[0]};
      u_r     <= {1'b0, tile[3:0]} + {4'd0, uv[1]};
      v_r     <= {1'b0, tile[7:4]} + {4'd0, uv[0]};
      light_r <= cur_r.light;
      clear_r <= cur_r.clear;
      last_r  <= face_done && (rem_clr == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign vertex_x       = vx_r;
  assign vertex_y       = vy_r;
  assign vertex_z       = vz_r;
  assign tex_u          = u_r;
  assign tex_v          = v_r;
  assign light_level    = light_r;
  assign to_translucent = clear_r;
  assign last_vertex    = last_r;

endmodule

>>> hdl/voxel_face_cull_mesher.sv
// ----------------------------------------------------------------------------
// voxel_face_cull_mesher
// culled-face mesher: one voxel per input beat, one vertex per output beat
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  in       in_valid / in_stall       block id, variant, light levels, neighbours
//  out      out_valid / out_stall     vertex position, atlas uv, light, flags
//  cfg      cfg_valid / cfg_ready     cfg_index, cfg_data (chunk origins)
//
//  the front takes one voxel per cycle while the four-entry queue has room
//  the back emits one vertex per cycle while out_stall is low:
//  6 per visible face, up to 36 per voxel
//  reset is synchronous and clears scan position, origins, queue and output
//  out_stall holds the output register; in_stall rises only on a full queue
// ----------------------------------------------------------------------------
module voxel_face_cull_mesher #(
  parameter int CHUNK_WIDTH  = 16,
  parameter int CHUNK_DEPTH  = 16,
  parameter int CHUNK_HEIGHT = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_block_kind,
  input  logic [3:0]  in_block_variant,
  input  logic [3:0]  in_sky_level,
  input  logic [3:0]  in_emitted_level,
  input  logic [7:0]  in_nbr_pos_x,
  input  logic [7:0]  in_nbr_neg_x,
  input  logic [7:0]  in_nbr_pos_y,
  input  logic [7:0]  in_nbr_neg_y,
  input  logic [7:0]  in_nbr_pos_z,
  input  logic [7:0]  in_nbr_neg_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] out_vertex_x,
  output logic [7:0]  out_vertex_y,
  output logic [16:0] out_vertex_z,
  output logic [4:0]  out_tex_u,
  output logic [4:0]  out_tex_v,
  output logic [3:0]  out_light_level,
  output logic        out_to_translucent,
  output logic        out_last_vertex,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);
  import vfcm_pkg::*;

  logic   q_full;
  logic   q_valid;
  logic   push;
  logic   pop;
  entry_t push_entry;
  entry_t head;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;

  vfcm_front #(
    .CHUNK_WIDTH  (CHUNK_WIDTH),
    .CHUNK_DEPTH  (CHUNK_DEPTH),
    .CHUNK_HEIGHT (CHUNK_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .q_full        (q_full),
    .block_kind    (in_block_kind),
    .block_variant (in_block_variant),
    .sky_level     (in_sky_level),
    .emitted_level (in_emitted_level),
    .nbr_pos_x     (in_nbr_pos_x),
    .nbr_neg_x     (in_nbr_neg_x),
    .nbr_pos_y     (in_nbr_pos_y),
    .nbr_neg_y     (in_nbr_neg_y),
    .nbr_pos_z     (in_nbr_pos_z),
    .nbr_neg_z     (in_nbr_neg_z),
    .cfg_wr        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .push_entry    (push_entry)
  );

  vfcm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .q_valid    (q_valid),
    .head       (head)
  );

  vfcm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .vertex_x       (out_vertex_x),
    .vertex_y       (out_vertex_y),
    .vertex_z       (out_vertex_z),
    .tex_u          (out_tex_u),
    .tex_v          (out_tex_v),
    .light_level    (out_light_level),
    .to_translucent (out_to_translucent),
    .last_vertex    (out_last_vertex)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_full))
    else $error("push into full queue");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");

  a_air_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_block_kind == AIR_ID)) |-> !push)
    else $error("air voxel queued");

  a_pop_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_valid && !push) |=> !pop)
    else $error("pop without queued voxel");

endmodule

>>> bench/vfcm_checker.sv
// ----------------------------------------------------------------------------
// vfcm_checker
// watches the voxel, vertex and config channels of the face cull mesher,
// predicts the vertices each accepted voxel must produce and compares every
// accepted vertex field by field against the oldest prediction
// ----------------------------------------------------------------------------
module vfcm_checker #(
  parameter int CHUNK_WIDTH  = 16,
  parameter int CHUNK_DEPTH  = 16,
  parameter int CHUNK_HEIGHT = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_block_kind,
  input  logic [3:0]  in_block_variant,
  input  logic [3:0]  in_sky_level,
  input  logic [3:0]  in_emitted_level,
  input  logic [7:0]  in_nbr_pos_x,
  input  logic [7:0]  in_nbr_neg_x,
  input  logic [7:0]  in_nbr_pos_y,
  input  logic [7:0]  in_nbr_neg_y,
  input  logic [7:0]  in_nbr_pos_z,
  input  logic [7:0]  in_nbr_neg_z,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [16:0] out_vertex_x,
  input  logic [7:0]  out_vertex_y,
  input  logic [16:0] out_vertex_z,
  input  logic [4:0]  out_tex_u,
  input  logic [4:0]  out_tex_v,
  input  logic [3:0]  out_light_level,
  input  logic        out_to_translucent,
  input  logic        out_last_vertex,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data,
  output int          mismatches,
  output int          open_vertices,
  output int          voxels_seen,
  output int          vertices_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import vfcm_pkg::*;

  typedef struct packed {
    logic [16:0] x;
    logic [7:0]  y;
    logic [16:0] z;
    logic [4:0]  u;
    logic [4:0]  v;
    logic [3:0]  light;
    logic        clear;
    logic        last;
  } vertex_t;

  // corner offsets {x, y, z} per face, faces ordered +x -x +y -y +z -z
  localparam bit [2:0] CORNER_XYZ [6][4] = '{
    '{3'b100, 3'b110, 3'b111, 3'b101},
    '{3'b001, 3'b011, 3'b010, 3'b000},
    '{3'b010, 3'b011, 3'b111, 3'b110},
    '{3'b001, 3'b000, 3'b100, 3'b101},
    '{3'b101, 3'b111, 3'b011, 3'b001},
    '{3'b000, 3'b010, 3'b110, 3'b100}
  };
  localparam bit CORNER_U [4] = '{1'b0, 1'b0, 1'b1, 1'b1};
  localparam bit CORNER_V [4] = '{1'b1, 1'b0, 1'b0, 1'b1};
  localparam int QUAD_SEQ [6] = '{0, 1, 2, 0, 2, 3};

  vertex_t     mesh_fifo [$];
  int          scan_x;
  int          scan_z;
  int          scan_y;
  logic [11:0] origin_x;
  logic [11:0] origin_z;

  function automatic bit lets_light_through(input logic [7:0] id);
    return id == CLEAR_WATER_A || id == CLEAR_WATER_B ||
           id == CLEAR_LEAVES || id == CLEAR_GLASS;
  endfunction

  function automatic bit face_exposed(input logic [7:0] cur, input logic [7:0] nb);
    if (nb == AIR_ID) return 1'b1;
    if (!lets_light_through(cur)) return lets_light_through(nb);
    return !lets_light_through(nb) || nb != cur;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [16:0] got,
                               input logic [16:0] want);
    if (got !== want) begin
      report($sformatf("vertex %0d %s: got %0h, want %0h",
                       vertices_checked, name, got, want));
    end
  endtask

  task automatic mesh_voxel(input logic [7:0] kind, input logic [3:0] variant,
                            input logic [3:0] sky, input logic [3:0] emit,
                            input logic [5:0][7:0] nbr);
    int      bx;
    int      bz;
    int      faces_left;
    int      c;
    logic [7:0] tile;
    logic [5:0] shown;
    vertex_t vt;
    if (kind != AIR_ID) begin
      bx = $signed(origin_x) * CHUNK_WIDTH + scan_x;
      bz = $signed(origin_z) * CHUNK_DEPTH + scan_z;
      faces_left = 0;
      for (int f = 0; f < 6; f++) begin
        shown[f] = face_exposed(kind, nbr[f]);
        faces_left += int'(shown[f]);
      end
      for (int f = 0; f < 6; f++) begin
        if (shown[f]) begin
          faces_left--;
          tile = 8'(int'(kind) * int'(TILE_ID_MUL) +
                    int'(variant) * int'(TILE_DATA_MUL) + f);
          for (int k = 0; k < 6; k++) begin
            c = QUAD_SEQ[k];
            vt.x     = 17'(bx + int'(CORNER_XYZ[f][c][2]));
            vt.y     = 8'(scan_y + int'(CORNER_XYZ[f][c][1]));
            vt.z     = 17'(bz + int'(CORNER_XYZ[f][c][0]));
            vt.u     = 5'(tile[3:0]) + 5'(CORNER_U[c]);
            vt.v     = 5'(tile[7:4]) + 5'(CORNER_V[c]);
            vt.light = sky > emit ? sky : emit;
            vt.clear = lets_light_through(kind);
            vt.last  = faces_left == 0 && k == 5;
            mesh_fifo = {mesh_fifo, vt};
          end
        end
      end
    end
    // scan order: y innermost, then z, then x
    scan_y++;
    if (scan_y >= CHUNK_HEIGHT) begin
      scan_y = 0;
      scan_z++;
      if (scan_z >= CHUNK_DEPTH) begin
        scan_z = 0;
        scan_x++;
        if (scan_x >= CHUNK_WIDTH) scan_x = 0;
      end
    end
  endtask

  task automatic check_vertex();
    vertex_t want;
    if (mesh_fifo.size() == 0) begin
      report($sformatf("vertex (%0h, %0h, %0h) arrived with none expected",
                       out_vertex_x, out_vertex_y, out_vertex_z));
    end else begin
      want = mesh_fifo.pop_front();
      compare_field("vertex_x", out_vertex_x, want.x);
      compare_field("vertex_y", 17'(out_vertex_y), 17'(want.y));
      compare_field("vertex_z", out_vertex_z, want.z);
      compare_field("tex_u", 17'(out_tex_u), 17'(want.u));
      compare_field("tex_v", 17'(out_tex_v), 17'(want.v));
      compare_field("light_level", 17'(out_light_level), 17'(want.light));
      compare_field("to_translucent", 17'(out_to_translucent), 17'(want.clear));
      compare_field("last_vertex", 17'(out_last_vertex), 17'(want.last));
      vertices_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      scan_x = 0;
      scan_z = 0;
      scan_y = 0;
      origin_x = '0;
      origin_z = '0;
      mesh_fifo.delete();
      mismatches = 0;
      voxels_seen = 0;
      vertices_checked = 0;
      open_vertices = 0;
    end else begin
      if (out_valid && !out_stall) check_vertex();
      if (in_valid && !in_stall) begin
        mesh_voxel(in_block_kind, in_block_variant, in_sky_level, in_emitted_level,
                   {in_nbr_neg_z, in_nbr_pos_z, in_nbr_neg_y, in_nbr_pos_y,
                    in_nbr_neg_x, in_nbr_pos_x});
        voxels_seen++;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CHUNK_X) origin_x = cfg_data;
        else origin_z = cfg_data;
      end
      open_vertices = mesh_fifo.size();
    end
  end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives voxels and chunk origins into the face cull mesher with random
// gaps and output stalls, a long output hold-off and a y scan wrap;
// the checker beside the block predicts and compares every vertex
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import vfcm_pkg::*;

  localparam int CW          = 16;
  localparam int CD          = 16;
  localparam int CH          = 128;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0]      kind;
    logic [3:0]      variant;
    logic [3:0]      sky;
    logic [3:0]      emit;
    logic [5:0][7:0] nbr;
  } voxel_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_block_kind;
  logic [3:0]  in_block_variant;
  logic [3:0]  in_sky_level;
  logic [3:0]  in_emitted_level;
  logic [7:0]  in_nbr_pos_x;
  logic [7:0]  in_nbr_neg_x;
  logic [7:0]  in_nbr_pos_y;
  logic [7:0]  in_nbr_neg_y;
  logic [7:0]  in_nbr_pos_z;
  logic [7:0]  in_nbr_neg_z;
  logic        out_valid;
  logic        out_stall;
  logic [16:0] out_vertex_x;
  logic [7:0]  out_vertex_y;
  logic [16:0] out_vertex_z;
  logic [4:0]  out_tex_u;
  logic [4:0]  out_tex_v;
  logic [3:0]  out_light_level;
  logic        out_to_translucent;
  logic        out_last_vertex;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [11:0] cfg_data;

  int mismatches;
  int open_vertices;
  int voxels_seen;
  int vertices_checked;
  int voxels_sent;
  int origin_settings;
  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_request;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  voxel_face_cull_mesher #(
    .CHUNK_WIDTH (CW),
    .CHUNK_DEPTH (CD),
    .CHUNK_HEIGHT(CH)
  ) u_dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_block_kind, .in_block_variant, .in_sky_level,
    .in_emitted_level, .in_nbr_pos_x, .in_nbr_neg_x, .in_nbr_pos_y, .in_nbr_neg_y,
    .in_nbr_pos_z, .in_nbr_neg_z,
    .out_valid, .out_stall, .out_vertex_x, .out_vertex_y, .out_vertex_z,
    .out_tex_u, .out_tex_v, .out_light_level, .out_to_translucent, .out_last_vertex,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  vfcm_checker #(
    .CHUNK_WIDTH (CW),
    .CHUNK_DEPTH (CD),
    .CHUNK_HEIGHT(CH)
  ) u_checker (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_block_kind, .in_block_variant, .in_sky_level,
    .in_emitted_level, .in_nbr_pos_x, .in_nbr_neg_x, .in_nbr_pos_y, .in_nbr_neg_y,
    .in_nbr_pos_z, .in_nbr_neg_z,
    .out_valid, .out_stall, .out_vertex_x, .out_vertex_y, .out_vertex_z,
    .out_tex_u, .out_tex_v, .out_light_level, .out_to_translucent, .out_last_vertex,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .open_vertices, .voxels_seen, .vertices_checked
  );

  function automatic logic [7:0] clear_id();
    case ($urandom_range(0, 3))
      0:       return CLEAR_WATER_A;
      1:       return CLEAR_WATER_B;
      2:       return CLEAR_LEAVES;
      default: return CLEAR_GLASS;
    endcase
  endfunction

  function automatic voxel_t make_voxel(
    input int kind, input int variant, input int sky,
    input int emit, input int px, input int nx,
    input int py, input int ny, input int pz,
    input int nz);
    voxel_t v;
    v.kind = 8'(kind);
    v.variant = 4'(variant);
    v.sky = 4'(sky);
    v.emit = 4'(emit);
    v.nbr = {8'(nz), 8'(pz), 8'(ny), 8'(py), 8'(nx), 8'(px)};
    return v;
  endfunction

  function automatic voxel_t random_voxel();
    voxel_t v;
    case ($urandom_range(0, 9))
      0, 1:    v.kind = AIR_ID;
      2, 3, 4: v.kind = clear_id();
      default: v.kind = 8'($urandom_range(1, 255));
    endcase
    v.variant = 4'($urandom_range(0, 15));
    v.sky = 4'($urandom_range(0, 15));
    v.emit = 4'($urandom_range(0, 15));
    for (int f = 0; f < 6; f++) begin
      case ($urandom_range(0, 3))
        0:       v.nbr[f] = AIR_ID;
        1:       v.nbr[f] = v.kind;
        2:       v.nbr[f] = clear_id();
        default: v.nbr[f] = 8'($urandom_range(0, 255));
      endcase
    end
    return v;
  endfunction

  // entered and left at a falling edge
  task automatic send_voxel(input voxel_t v);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_block_kind <= v.kind;
    in_block_variant <= v.variant;
    in_sky_level <= v.sky;
    in_emitted_level <= v.emit;
    in_nbr_pos_x <= v.nbr[0];
    in_nbr_neg_x <= v.nbr[1];
    in_nbr_pos_y <= v.nbr[2];
    in_nbr_neg_y <= v.nbr[3];
    in_nbr_pos_z <= v.nbr[4];
    in_nbr_neg_z <= v.nbr[5];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    voxels_sent++;
    @(negedge clk);
  endtask

  // stop offering, wait for every vertex, then let hidden voxels drain
  task automatic drain();
    in_valid <= 1'b0;
    while (open_vertices != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic set_origins(input logic [11:0] ox, input logic [11:0] oz);
    cfg_index <= REG_CHUNK_X;
    cfg_data <= ox;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= REG_CHUNK_Z;
    cfg_data <= oz;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    origin_settings++;
  endtask

  task automatic run_batch(input int count);
    repeat (count) send_voxel(random_voxel());
    drain();
  endtask

  // receiver: per vertex beat a random hold-off, or one long one on request
  initial begin : receiver
    int gap;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      gap = rx_idle_on ? $urandom_range(0, 14) : 0;
      if (hold_request) begin
        gap = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d vertices outstanding", open_vertices);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    voxel_t v;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_block_kind = '0;
    in_block_variant = '0;
    in_sky_level = '0;
    in_emitted_level = '0;
    in_nbr_pos_x = '0;
    in_nbr_neg_x = '0;
    in_nbr_pos_y = '0;
    in_nbr_neg_y = '0;
    in_nbr_pos_z = '0;
    in_nbr_neg_z = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_CHUNK_X;
    cfg_data = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_request = 1'b0;
    voxels_sent = 0;
    origin_settings = 1;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed voxels at the reset origins
    send_voxel(make_voxel(int'(AIR_ID), 15, 15, 15, 255, 255, 255, 255, 255, 255));
    send_voxel(make_voxel(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_voxel(make_voxel(1, 1, 3, 7, 1, 2, 3, 4, 5, 255));
    for (int f = 0; f < 6; f++) begin
      v = make_voxel(2, f, f, 15 - f, 7, 7, 7, 7, 7, 7);
      v.nbr[f] = AIR_ID;
      send_voxel(v);
    end
    send_voxel(make_voxel(255, 15, 15, 0, 8, 9, 18, 20, 1, 0));
    send_voxel(make_voxel(8, 3, 0, 15, 8, 8, 8, 8, 8, 8));
    send_voxel(make_voxel(8, 6, 9, 9, 9, 18, 20, 1, 255, 0));
    send_voxel(make_voxel(9, 15, 15, 15, 9, 9, 8, 9, 0, 9));
    send_voxel(make_voxel(18, 10, 4, 12, 18, 20, 1, 18, 255, 18));
    send_voxel(make_voxel(20, 0, 0, 0, 20, 20, 20, 20, 20, 20));
    send_voxel(make_voxel(20, 9, 12, 4, 20, 20, 20, 20, 20, 9));
    send_voxel(make_voxel(170, 5, 0, 15, 0, 85, 0, 170, 0, 255));
    send_voxel(make_voxel(85, 10, 15, 0, 255, 0, 85, 0, 170, 0));
    drain();

    set_origins(12'h7FF, 12'h800);
    run_batch(30);

    // long output hold-off while voxels keep coming
    set_origins(12'h800, 12'h7FF);
    tx_idle_on = 1'b0;
    hold_request = 1'b1;
    run_batch(20);

    set_origins(12'($urandom), 12'($urandom));
    rx_idle_on = 1'b0;
    run_batch(20);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    set_origins(12'h7FF, 12'h7FF);
    run_batch(20);

    // crosses the top of the y scan into the next z column
    set_origins(12'h800, 12'h800);
    run_batch(22);
    repeat (30) @(negedge clk);

    $display("ran %0d voxels and checked %0d vertices over %0d origin settings",
             voxels_seen, vertices_checked, origin_settings);
    $display("included a %0d-cycle output hold-off, a y scan wrap, idle and busy runs",
             HOLD_CYCLES);
    if (open_vertices != 0) begin
      $display("%0d expected vertices never arrived", open_vertices);
    end
    if (mismatches == 0 && open_vertices == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
